// File: rtl/core/rrr_pkg.sv
// ----------------------------------------------------------------------------
// rrr_pkg
// Widths, types and helpers shared by the ray reflect / refract datapath.
// ----------------------------------------------------------------------------
package rrr_pkg;

  // field formats
  localparam int FIELD_W   = 18;
  localparam int FRAC_BITS = 16;
  localparam int RATIO_W   = 16;

  localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(49275);

  localparam int HALF  = 2 ** (FRAC_BITS - 1);
  localparam int RHALF = 2 ** (RATIO_W - 1);
  localparam int ONE   = 2 ** FRAC_BITS;

  // intermediate widths
  localparam int PROD_W  = 2 * FIELD_W;          // i*n
  localparam int DOT_W   = PROD_W + 1;           // sum of three products
  localparam int C_W     = DOT_W - FRAC_BITS;    // c
  localparam int CN_W    = C_W + FIELD_W;        // c*n
  localparam int CN2_W   = CN_W + 1;             // 2*c*n
  localparam int TERM_W  = CN2_W - FRAC_BITS;    // rescaled normal term
  localparam int SUM_W   = TERM_W + 1;           // before saturation
  localparam int F_W     = RATIO_W + 1;          // f as a signed operand
  localparam int FC_P_W  = F_W + C_W;            // f*c
  localparam int FC_W    = C_W;                  // f*c rescaled
  localparam int FI_P_W  = F_W + FIELD_W;        // f*i
  localparam int FI_W    = FI_P_W - RATIO_W;     // f*i rescaled
  localparam int FF_P_W  = 2 * RATIO_W;          // f*f
  localparam int FF_W    = RATIO_W + 1;          // f*f rescaled
  localparam int FCSQ_W  = 2 * FC_W;             // (f*c)^2
  localparam int FC2_W   = 24;                   // (f*c)^2 rescaled
  localparam int RAD_W   = 24;                   // clamped radicand
  localparam int RADC_W  = RAD_W + 2;            // radicand before clamp
  localparam int SQ_IN_W = RAD_W + FRAC_BITS;    // square root operand
  localparam int ROOT_W  = SQ_IN_W / 2;          // c2
  localparam int REM_W   = ROOT_W + 2;           // square root remainder
  localparam int T_W     = ROOT_W + 2;           // refraction normal scale
  localparam int TN_W    = T_W + FIELD_W;        // t*n

  // pipeline depth: seven front stages, one per root bit, three back stages
  localparam int NSQ  = ROOT_W;
  localparam int NSTG = 7 + NSQ + 3;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(2 ** (FIELD_W - 1) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-(2 ** (FIELD_W - 1)));

  typedef logic signed [FIELD_W-1:0] field_t;
  typedef logic signed [FI_W-1:0]    fi_t;
  typedef logic signed [FC_W-1:0]    fc_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  // values that ride alongside the square root
  typedef struct packed {
    fc_t          fc;
    logic         cneg;
    field_t [2:0] n;
    fi_t [2:0]    fi;
    field_t [2:0] refl;
  } side_t;

  function automatic field_t sat_field(input sum_t v);
    field_t res;
    if (v > SAT_HI) begin
      res = SAT_HI[FIELD_W-1:0];
    end else if (v < SAT_LO) begin
      res = SAT_LO[FIELD_W-1:0];
    end else begin
      res = v[FIELD_W-1:0];
    end
    return res;
  endfunction

endpackage

// File: rtl/core/rrr_in_if.sv
// ----------------------------------------------------------------------------
// rrr_in_if
// Input channel: incoming direction and surface normal, valid/ready.
// ----------------------------------------------------------------------------
interface rrr_in_if;
  import rrr_pkg::*;

  logic   valid;
  logic   ready;
  field_t incoming_x;
  field_t incoming_y;
  field_t incoming_z;
  field_t normal_x;
  field_t normal_y;
  field_t normal_z;

  modport source (
    output valid, incoming_x, incoming_y, incoming_z, normal_x, normal_y, normal_z,
    input  ready
  );

  modport sink (
    input  valid, incoming_x, incoming_y, incoming_z, normal_x, normal_y, normal_z,
    output ready
  );
endinterface

// File: rtl/core/rrr_out_if.sv
// ----------------------------------------------------------------------------
// rrr_out_if
// Result channel: reflected and refracted directions, valid/ready.
// ----------------------------------------------------------------------------
interface rrr_out_if;
  import rrr_pkg::*;

  logic   valid;
  logic   ready;
  field_t reflected_x;
  field_t reflected_y;
  field_t reflected_z;
  field_t refracted_x;
  field_t refracted_y;
  field_t refracted_z;

  modport source (
    output valid, reflected_x, reflected_y, reflected_z,
           refracted_x, refracted_y, refracted_z,
    input  ready
  );

  modport sink (
    input  valid, reflected_x, reflected_y, reflected_z,
           refracted_x, refracted_y, refracted_z,
    output ready
  );
endinterface

// File: rtl/core/rrr_sqrt.sv
// ----------------------------------------------------------------------------
// rrr_sqrt
// Pipelined restoring integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module rrr_sqrt (
  input  logic                         clk,
  input  logic                         en,
  input  logic [rrr_pkg::SQ_IN_W-1:0]  rad_i,
  output logic [rrr_pkg::ROOT_W-1:0]   root_o
);
  import rrr_pkg::*;

  logic [REM_W-1:0]   rem_r [NSQ-1];
  logic [SQ_IN_W-1:0] v_r   [NSQ-1];
  logic [ROOT_W-1:0]  q_r   [NSQ];

  logic [REM_W-1:0]   rem_nxt [NSQ];
  logic [SQ_IN_W-1:0] v_nxt   [NSQ];
  logic [ROOT_W-1:0]  q_nxt   [NSQ];

  always_comb begin
    logic [REM_W+1:0]   sh;
    logic [REM_W+1:0]   trial;
    logic [REM_W-1:0]   rem_in;
    logic [ROOT_W-1:0]  q_in;
    logic [SQ_IN_W-1:0] v_in;
    logic               ge;
    for (int k = 0; k < NSQ; k++) begin
      if (k == 0) begin
        rem_in = '0;
        q_in   = '0;
        v_in   = rad_i;
      end else begin
        rem_in = rem_r[k-1];
        q_in   = q_r[k-1];
        v_in   = v_r[k-1];
      end
      // bring down the next two operand bits, try 4q+1
      sh    = {rem_in, v_in[SQ_IN_W-1 -: 2]};
      trial = {2'b00, q_in, 2'b01};
      ge    = (sh >= trial);
      rem_nxt[k] = ge ? REM_W'(sh - trial) : sh[REM_W-1:0];
      q_nxt[k]   = {q_in[ROOT_W-2:0], ge};
      v_nxt[k]   = v_in << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NSQ; k++) begin
        q_r[k] <= q_nxt[k];
      end
      for (int k = 0; k < NSQ - 1; k++) begin
        rem_r[k] <= rem_nxt[k];
        v_r[k]   <= v_nxt[k];
      end
    end
  end

  assign root_o = q_r[NSQ-1];

endmodule

// File: rtl/core/ray_reflect_refract_core.sv
// ----------------------------------------------------------------------------
// ray_reflect_refract_core
// Mirror reflection and Snell refraction of a ray about a surface normal.
// ----------------------------------------------------------------------------
// Takes one ray (incoming direction and unit normal, signed Q1.16) per cycle
// and returns its reflected and refracted directions, one result beat per
// cycle. The depth is set by the refraction square root, which resolves one
// root bit per stage over 20 stages, plus seven stages of dot product and
// scaling ahead of it and three behind it. The whole pipe holds while a
// finished beat waits at the output, so nothing is dropped.
// The index ratio register (unsigned Q0.16, reset 1/1.33) is written through
// cfg_we / cfg_wdata and should only change while no rays are in flight.
// ----------------------------------------------------------------------------
module ray_reflect_refract_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [rrr_pkg::RATIO_W-1:0]  cfg_wdata,
  rrr_in_if.sink                       in_ray,
  rrr_out_if.source                    out_ray
);
  import rrr_pkg::*;

  logic [RATIO_W-1:0] ratio_r;
  logic [NSTG-1:0]    vld_r;
  logic               adv;
  logic signed [F_W-1:0] f_s;

  // stage 1..3: dot product and c
  logic signed [PROD_W-1:0] p_r [3];
  field_t                   i1_r [3];
  field_t                   n1_r [3];
  logic signed [DOT_W-1:0]  dot_r;
  field_t                   i2_r [3];
  field_t                   n2_r [3];
  logic signed [C_W-1:0]    c_r;
  field_t                   i3_r [3];
  field_t                   n3_r [3];

  // stage 4: products with c and f
  logic signed [CN_W-1:0]   cn_r [3];
  logic signed [FC_P_W-1:0] fcp_r;
  logic signed [FI_P_W-1:0] fip_r [3];
  logic [FF_P_W-1:0]        ffp_r;
  logic                     cneg4_r;
  field_t                   i4_r [3];
  field_t                   n4_r [3];

  // stage 5..7: reflection done, radicand built
  side_t                    side5_nxt;
  side_t                    side5_r;
  logic [FF_W-1:0]          ff5_nxt;
  logic [FF_W-1:0]          ff5_r;
  logic signed [FCSQ_W-1:0] fcsq_r;
  logic [FF_W-1:0]          ff6_r;
  side_t                    side6_r;
  logic [RAD_W-1:0]         rad_nxt;
  logic [RAD_W-1:0]         rad_r;
  side_t                    side7_r;

  // square root and its sideband
  logic [ROOT_W-1:0]        root;
  side_t                    side_dl_r [NSQ];

  // back stages
  logic signed [T_W-1:0]    t_nxt;
  logic signed [T_W-1:0]    t_r;
  side_t                    side28_r;
  logic signed [TN_W-1:0]   tnp_r [3];
  side_t                    side29_r;
  field_t                   refr_nxt [3];
  field_t                   refl_out_r [3];
  field_t                   refr_out_r [3];

  logic signed [DOT_W-1:0]  dot_nxt;
  logic signed [C_W-1:0]    c_nxt;

  // one enable for the whole pipe: move unless the output beat is stuck
  assign adv          = !vld_r[NSTG-1] || out_ray.ready;
  assign in_ray.ready = adv;
  assign f_s          = signed'({1'b0, ratio_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r <= RATIO_RESET;
      vld_r   <= '0;
    end else begin
      if (cfg_we) begin
        ratio_r <= cfg_wdata;
      end
      if (adv) begin
        vld_r <= {vld_r[NSTG-2:0], in_ray.valid};
      end
    end
  end

  // ---- dot product and c ----
  always_comb begin
    logic signed [DOT_W-1:0] negd;
    dot_nxt = DOT_W'(p_r[0]) + DOT_W'(p_r[1]) + DOT_W'(p_r[2]);
    negd    = -dot_r + DOT_W'(HALF);
    c_nxt   = negd[DOT_W-1:FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r[0]  <= in_ray.incoming_x * in_ray.normal_x;
      p_r[1]  <= in_ray.incoming_y * in_ray.normal_y;
      p_r[2]  <= in_ray.incoming_z * in_ray.normal_z;
      i1_r[0] <= in_ray.incoming_x;
      i1_r[1] <= in_ray.incoming_y;
      i1_r[2] <= in_ray.incoming_z;
      n1_r[0] <= in_ray.normal_x;
      n1_r[1] <= in_ray.normal_y;
      n1_r[2] <= in_ray.normal_z;
      dot_r   <= dot_nxt;
      c_r     <= c_nxt;
      fcp_r   <= f_s * c_r;
      ffp_r   <= ratio_r * ratio_r;
      cneg4_r <= c_r[C_W-1];
      for (int k = 0; k < 3; k++) begin
        i2_r[k]  <= i1_r[k];
        n2_r[k]  <= n1_r[k];
        i3_r[k]  <= i2_r[k];
        n3_r[k]  <= n2_r[k];
        cn_r[k]  <= c_r * n3_r[k];
        fip_r[k] <= f_s * i3_r[k];
        i4_r[k]  <= i3_r[k];
        n4_r[k]  <= n3_r[k];
      end
    end
  end

  // ---- reflection, f*c, f*i, f*f rescaled ----
  always_comb begin
    logic signed [CN2_W-1:0]  cn2;
    logic signed [TERM_W-1:0] term;
    logic signed [FC_P_W-1:0] fcr;
    logic signed [FI_P_W-1:0] fir;
    logic [FF_P_W:0]          ffr;
    fcr = fcp_r + FC_P_W'(RHALF);
    ffr = {1'b0, ffp_r} + (FF_P_W + 1)'(RHALF);
    side5_nxt.fc   = fcr[FC_P_W-2:RATIO_W];
    side5_nxt.cneg = cneg4_r;
    ff5_nxt        = ffr[FF_P_W:RATIO_W];
    for (int k = 0; k < 3; k++) begin
      cn2  = signed'({cn_r[k], 1'b0}) + CN2_W'(HALF);
      term = cn2[CN2_W-1:FRAC_BITS];
      fir  = fip_r[k] + FI_P_W'(RHALF);
      side5_nxt.refl[k] = sat_field(SUM_W'(i4_r[k]) + SUM_W'(term));
      side5_nxt.fi[k]   = fir[FI_P_W-1:RATIO_W];
      side5_nxt.n[k]    = n4_r[k];
    end
  end

  // ---- radicand (1 - f*f) + (f*c)^2, clamped at zero ----
  always_comb begin
    logic [FCSQ_W-1:0]        fcsq_rnd;
    logic [FC2_W-1:0]         fc2;
    logic signed [RADC_W-1:0] radc;
    fcsq_rnd = fcsq_r + FCSQ_W'(HALF);
    fc2      = fcsq_rnd[FRAC_BITS+FC2_W-1:FRAC_BITS];
    radc     = RADC_W'(ONE) - RADC_W'(ff6_r) + RADC_W'(fc2);
    rad_nxt  = radc[RADC_W-1] ? '0 : radc[RAD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side5_r <= side5_nxt;
      ff5_r   <= ff5_nxt;
      fcsq_r  <= side5_r.fc * side5_r.fc;
      ff6_r   <= ff5_r;
      side6_r <= side5_r;
      rad_r   <= rad_nxt;
      side7_r <= side6_r;
    end
  end

  rrr_sqrt u_sqrt (
    .clk    (clk),
    .en     (adv),
    .rad_i  ({rad_r, FRAC_BITS'(0)}),
    .root_o (root)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      side_dl_r[0] <= side7_r;
      for (int k = 1; k < NSQ; k++) begin
        side_dl_r[k] <= side_dl_r[k-1];
      end
    end
  end

  // ---- refraction: t = +-(f*c - c2), then f*i + t*n ----
  always_comb begin
    logic signed [T_W-1:0] fc_ext;
    logic signed [T_W-1:0] root_ext;
    fc_ext   = T_W'(side_dl_r[NSQ-1].fc);
    root_ext = signed'(T_W'(root));
    t_nxt    = side_dl_r[NSQ-1].cneg ? (root_ext - fc_ext) : (fc_ext - root_ext);
  end

  always_comb begin
    logic signed [TN_W-1:0]   tnr;
    logic signed [TERM_W-1:0] term;
    for (int k = 0; k < 3; k++) begin
      tnr  = tnp_r[k] + TN_W'(HALF);
      term = tnr[TN_W-1:FRAC_BITS];
      refr_nxt[k] = sat_field(SUM_W'(side29_r.fi[k]) + SUM_W'(term));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_r      <= t_nxt;
      side28_r <= side_dl_r[NSQ-1];
      side29_r <= side28_r;
      for (int k = 0; k < 3; k++) begin
        tnp_r[k]      <= t_r * side28_r.n[k];
        refl_out_r[k] <= side29_r.refl[k];
        refr_out_r[k] <= refr_nxt[k];
      end
    end
  end

  assign out_ray.valid       = vld_r[NSTG-1];
  assign out_ray.reflected_x = refl_out_r[0];
  assign out_ray.reflected_y = refl_out_r[1];
  assign out_ray.reflected_z = refl_out_r[2];
  assign out_ray.refracted_x = refr_out_r[0];
  assign out_ray.refracted_y = refr_out_r[1];
  assign out_ray.refracted_z = refr_out_r[2];

  // ---- checks ----
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_ray.valid)
    else $error("result beat valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline moved while the output beat was stalled");

  a_advance_shifts: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> vld_r[NSTG-1:1] == $past(vld_r[NSTG-2:0]))
    else $error("valid bits did not travel one stage on advance");

endmodule
